// ----- sv/sor_pkg.sv -----
// Package for the SOR seven-point stencil solver.
// Holds widths, operation, status and register codes for the top and testbench.
// No dependencies.
package sor_pkg;

    localparam int SOR_MAX_CELLS  = 4096;
    localparam int SOR_MIN_SWEEPS = 5;

    localparam int VAL_W     = 32;   // Q16.16 word
    localparam int OP_W      = 2;
    localparam int CIDX_W    = 12;   // cell_index port width
    localparam int SIZE_W    = 13;
    localparam int TOL_W     = 32;
    localparam int RELAX_W   = 15;
    localparam int ITER_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SUM_W     = 48;
    localparam int IDX_W     = 28;   // linear index arithmetic, covers size_x*size_y
    localparam int SLOTS     = 7;
    localparam int SLOT_W    = 3;
    localparam int COEF_ROW_W = SLOTS * VAL_W;
    localparam int ACC_W     = 52;   // residual accumulator
    localparam int DIV_NUM_W = 63;   // |r| << 16
    localparam int DIV_DEN_W = 32;   // |center|

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_SOLVE  = 2'd1,
        OP_READ   = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_CAP    = 2'd1,
        ST_ZERO   = 2'd2,
        ST_RSVD   = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_SIZE_X = 3'd1,
        CFG_SIZE_Y = 3'd2,
        CFG_SIZE_Z = 3'd3,
        CFG_TOTAL  = 3'd4,
        CFG_TOL    = 3'd5,
        CFG_RELAX  = 3'd6,
        CFG_MAXIT  = 3'd7
    } cfg_idx_t;

    localparam logic [SLOT_W-1:0] SLOT_CENTER = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_LAST   = 3'd6;

endpackage

// ----- sv/sor_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module sor_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, hold when idle
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- sv/sor_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Used for the residual / center division; depends on nothing.
module sor_div #(
    parameter int NUM_W = 63,
    parameter int DEN_W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // one restoring step
    always_comb begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[DEN_W-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = num_reg;
endmodule

// ----- sv/sor_stencil7_solver.sv -----
// SOR seven-point stencil solver, top level.
// Depends on sor_pkg, sor_ram, sor_div.
//
// Usage: the s_ channel carries commands (load cell, solve, read cell), the
// m_ channel returns one result beat per command. The cfg_ port writes the
// eight control registers; the user writes them only while the block is idle,
// which the block does not enforce. Load: all seven coefficients, rhs and
// starting guess go to memory in the accept cycle; a load beat is taken every
// cycle while the result register drains. Read: the solution memory is read
// in the accept cycle, the result is registered in S_READ and no new command
// is taken there. Solve: S_SETUP1, S_SETUP2, then per sweep each cell runs
// S_FETCH, S_MUL (shared 32x32 multiplier) and S_ACC per neighbor slot, the
// bit-serial divider (skipped on a zero center; it sets the per-cell time),
// S_BLEND and S_WRITE to blend and write back; S_CONV tests convergence.
// Reset clears control state and restores the register defaults; the cell
// memories are not cleared and must be loaded before use.
// A result waits in the output register while m_ready is low; a new command
// is taken in S_IDLE when that register is empty or emptied in the same cycle.
module sor_stencil7_solver
    import sor_pkg::*;
#(
    parameter int MAX_CELLS  = sor_pkg::SOR_MAX_CELLS,
    parameter int MIN_SWEEPS = sor_pkg::SOR_MIN_SWEEPS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [sor_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sor_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sor_pkg::OP_W-1:0]            s_operation,
    input  logic [sor_pkg::CIDX_W-1:0]          s_cell_index,
    input  logic signed [sor_pkg::VAL_W-1:0]    s_coeff_back_z,
    input  logic signed [sor_pkg::VAL_W-1:0]    s_coeff_back_y,
    input  logic signed [sor_pkg::VAL_W-1:0]    s_coeff_back_x,
    input  logic signed [sor_pkg::VAL_W-1:0]    s_coeff_center,
    input  logic signed [sor_pkg::VAL_W-1:0]    s_coeff_front_x,
    input  logic signed [sor_pkg::VAL_W-1:0]    s_coeff_front_y,
    input  logic signed [sor_pkg::VAL_W-1:0]    s_coeff_front_z,
    input  logic signed [sor_pkg::VAL_W-1:0]    s_rhs_value,
    input  logic signed [sor_pkg::VAL_W-1:0]    s_initial_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [sor_pkg::VAL_W-1:0]    m_cell_value,
    output logic [sor_pkg::ITER_W-1:0]          m_iteration_count,
    output logic [sor_pkg::STATUS_W-1:0]        m_status
);
    localparam int AW = $clog2(MAX_CELLS);
    localparam int CW = AW + 1;
    localparam int VOL_W = IDX_W + SIZE_W;

    localparam logic signed [ACC_W-1:0] RESID_POS = ACC_W'(64'sd140737488355327);
    localparam logic signed [ACC_W-1:0] RESID_NEG = -RESID_POS;
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [15:0] {
        S_IDLE        = 16'b0000_0000_0000_0001,
        S_READ        = 16'b0000_0000_0000_0010,
        S_SETUP1      = 16'b0000_0000_0000_0100,
        S_SETUP2      = 16'b0000_0000_0000_1000,
        S_SWEEP_START = 16'b0000_0000_0001_0000,
        S_CELL_START  = 16'b0000_0000_0010_0000,
        S_FETCH       = 16'b0000_0000_0100_0000,
        S_MUL         = 16'b0000_0000_1000_0000,
        S_ACC         = 16'b0000_0001_0000_0000,
        S_DIV_START   = 16'b0000_0010_0000_0000,
        S_DIV_WAIT    = 16'b0000_0100_0000_0000,
        S_BLEND       = 16'b0000_1000_0000_0000,
        S_WRITE       = 16'b0001_0000_0000_0000,
        S_SWEEP_END   = 16'b0010_0000_0000_0000,
        S_CONV        = 16'b0100_0000_0000_0000,
        S_DONE        = 16'b1000_0000_0000_0000
    } state_t;

    // ---------------- configuration registers ----------------
    logic               mode_reg;
    logic [SIZE_W-1:0]  size_x_reg, size_y_reg, size_z_reg, total_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [RELAX_W-1:0] relax_reg;
    logic [ITER_W-1:0]  max_iter_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= 1'b0;
            size_x_reg   <= SIZE_W'(16);
            size_y_reg   <= SIZE_W'(16);
            size_z_reg   <= SIZE_W'(16);
            total_reg    <= SIZE_W'(4096);
            tol_reg      <= TOL_W'(4295);
            relax_reg    <= RELAX_W'(31130);
            max_iter_reg <= ITER_W'(1000);
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_MODE:   mode_reg     <= cfg_wdata[0];
                CFG_SIZE_X: size_x_reg   <= cfg_wdata[SIZE_W-1:0];
                CFG_SIZE_Y: size_y_reg   <= cfg_wdata[SIZE_W-1:0];
                CFG_SIZE_Z: size_z_reg   <= cfg_wdata[SIZE_W-1:0];
                CFG_TOTAL:  total_reg    <= cfg_wdata[SIZE_W-1:0];
                CFG_TOL:    tol_reg      <= cfg_wdata[TOL_W-1:0];
                CFG_RELAX:  relax_reg    <= cfg_wdata[RELAX_W-1:0];
                CFG_MAXIT:  max_iter_reg <= cfg_wdata[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    state_t state_reg, state_next;
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic [ITER_W-1:0]       out_count_reg;
    logic [STATUS_W-1:0]     out_status_reg;

    logic [ITER_W-1:0]  sweep_cnt_reg;
    logic               zdiv_reg;
    logic [SUM_W-1:0]   sum_new_reg, sum_old_reg;
    logic [IDX_W-1:0]   sxy_reg, zwrap_reg, ywrap_reg, xwrap_reg;
    logic [VOL_W-1:0]   vol_reg;
    logic [CW-1:0]      n_reg;
    logic [IDX_W-1:0]   c_reg, cij_reg;
    logic [SIZE_W-1:0]  xi_reg, yj_reg, zk_reg;
    logic [AW-1:0]      nb_addr_reg [SLOTS];
    logic [SLOTS-1:0]   nb_pres_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic signed [2*VAL_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [VAL_W-1:0]   old_reg, cen_reg, t_reg;
    logic                      neg_reg;
    logic signed [VAL_W+RELAX_W+2:0] blend_reg;
    logic [SUM_W-1:0]   diff_reg;
    logic [SUM_W-1:0]   conv_hi_reg;
    logic [2*TOL_W-1:0] conv_lo_reg;

    logic in_fire, out_fire;
    logic in_range;
    logic in_range_reg;
    logic [AW-1:0] in_addr;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign s_ready  = (state_reg == S_IDLE) && (!out_valid_reg || m_ready);
    assign in_range = (32'(s_cell_index) < MAX_CELLS);
    assign in_addr  = AW'(s_cell_index);

    // ---------------- memories ----------------
    logic                  coef_re, sol_we, sol_re, load_we;
    logic [AW-1:0]         sol_waddr, sol_raddr;
    logic [VAL_W-1:0]      sol_wdata, sol_rdata, rhs_rdata;
    logic [COEF_ROW_W-1:0] coef_wdata, coef_rdata;

    assign load_we    = in_fire && (s_operation == OP_LOAD) && in_range;
    assign coef_wdata = {s_coeff_front_z, s_coeff_front_y, s_coeff_front_x, s_coeff_center,
                         s_coeff_back_x, s_coeff_back_y, s_coeff_back_z};
    assign coef_re    = (state_reg == S_CELL_START);

    sor_ram #(.DATA_W(COEF_ROW_W), .DEPTH(MAX_CELLS)) u_coef_ram (
        .aclk(aclk), .we(load_we), .waddr(in_addr), .wdata(coef_wdata),
        .re(coef_re), .raddr(c_reg[AW-1:0]), .rdata(coef_rdata)
    );

    sor_ram #(.DATA_W(VAL_W), .DEPTH(MAX_CELLS)) u_rhs_ram (
        .aclk(aclk), .we(load_we), .waddr(in_addr), .wdata(s_rhs_value),
        .re(coef_re), .raddr(c_reg[AW-1:0]), .rdata(rhs_rdata)
    );

    sor_ram #(.DATA_W(VAL_W), .DEPTH(MAX_CELLS)) u_sol_ram (
        .aclk(aclk), .we(sol_we), .waddr(sol_waddr), .wdata(sol_wdata),
        .re(sol_re), .raddr(sol_raddr), .rdata(sol_rdata)
    );

    // ---------------- divider ----------------
    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_quo;
    logic [DIV_DEN_W-1:0] div_den;

    sor_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(div_den), .done(div_done), .quo(div_quo)
    );

    // ---------------- neighbor addresses for the current cell ----------------
    logic [IDX_W-1:0] nx_w, n_w;
    logic [IDX_W-1:0] nb_idx [SLOTS];
    logic [SLOTS-1:0] nb_pres;

    assign nx_w = IDX_W'(size_x_reg);
    assign n_w  = IDX_W'(n_reg);

    always_comb begin
        nb_idx[SLOT_CENTER] = c_reg;
        nb_pres = '0;
        if (!mode_reg) begin
            nb_idx[0] = c_reg - sxy_reg;
            nb_idx[1] = c_reg - nx_w;
            nb_idx[2] = c_reg - 1'b1;
            nb_idx[4] = c_reg + 1'b1;
            nb_idx[5] = c_reg + nx_w;
            nb_idx[6] = c_reg + sxy_reg;
            nb_pres[0] = (c_reg >= sxy_reg);
            nb_pres[1] = (c_reg >= nx_w);
            nb_pres[2] = (c_reg != '0);
            nb_pres[4] = (nb_idx[4] < n_w);
            nb_pres[5] = (nb_idx[5] < n_w);
            nb_pres[6] = (nb_idx[6] < n_w);
        end else begin
            nb_idx[0] = (zk_reg == SIZE_W'(1)) ? c_reg + zwrap_reg : c_reg - sxy_reg;
            nb_idx[6] = (zk_reg == size_z_reg - 2'd2) ? c_reg - zwrap_reg : c_reg + sxy_reg;
            nb_idx[1] = (yj_reg == SIZE_W'(1)) ? c_reg + ywrap_reg : c_reg - nx_w;
            nb_idx[5] = (yj_reg == size_y_reg - 2'd2) ? c_reg - ywrap_reg : c_reg + nx_w;
            nb_idx[2] = (xi_reg == SIZE_W'(1)) ? c_reg + xwrap_reg : c_reg - 1'b1;
            nb_idx[4] = (xi_reg == size_x_reg - 2'd2) ? c_reg - xwrap_reg : c_reg + 1'b1;
            nb_pres = '1;
            nb_pres[SLOT_CENTER] = 1'b0;
        end
    end

    // ---------------- arithmetic helpers ----------------
    logic signed [VAL_W-1:0] coef_slot;
    logic signed [ACC_W-1:0] r_sat;
    logic [ACC_W-1:0]        r_mag;
    logic [VAL_W-1:0]        cen_mag;
    logic signed [VAL_W-1:0] t_div;
    logic signed [VAL_W:0]   diff_t;
    logic signed [VAL_W+4:0] new_wide;
    logic signed [VAL_W-1:0] new_val;
    logic [VAL_W-1:0]        new_mag, old_mag;
    logic [SUM_W:0]          conv_lim;
    logic                    last_cell, converged;
    logic [SIZE_W-1:0]       z_last, y_last, x_last;

    assign coef_slot = coef_rdata[slot_reg*VAL_W +: VAL_W];

    // clamp residual to +-(2^47-1)
    always_comb begin
        if (acc_reg > RESID_POS) begin
            r_sat = RESID_POS;
        end else if (acc_reg < RESID_NEG) begin
            r_sat = RESID_NEG;
        end else begin
            r_sat = acc_reg;
        end
        r_mag   = r_sat[ACC_W-1] ? ACC_W'(-r_sat) : ACC_W'(r_sat);
        cen_mag = cen_reg[VAL_W-1] ? VAL_W'(-cen_reg) : VAL_W'(cen_reg);
    end

    assign div_num   = {r_mag[46:0], 16'b0};
    assign div_den   = cen_mag;
    assign div_start = (state_reg == S_DIV_START) && (cen_reg != '0);

    // sign and saturate the quotient
    always_comb begin
        if (neg_reg) begin
            if (div_quo > DIV_NUM_W'(64'h8000_0000)) begin
                t_div = VAL_MIN;
            end else begin
                t_div = VAL_W'(-div_quo);
            end
        end else begin
            if (div_quo > DIV_NUM_W'(64'h7FFF_FFFF)) begin
                t_div = VAL_MAX;
            end else begin
                t_div = VAL_W'(div_quo);
            end
        end
    end

    assign diff_t = (VAL_W+1)'(t_reg) - (VAL_W+1)'(old_reg);

    // old + floor(w*(t-old) / 2^14), saturated
    always_comb begin
        new_wide = (VAL_W+5)'(old_reg) + (VAL_W+5)'(blend_reg >>> 14);
        if (new_wide > (VAL_W+5)'(VAL_MAX)) begin
            new_val = VAL_MAX;
        end else if (new_wide < (VAL_W+5)'(VAL_MIN)) begin
            new_val = VAL_MIN;
        end else begin
            new_val = VAL_W'(new_wide);
        end
        new_mag = new_val[VAL_W-1] ? VAL_W'(-new_val) : VAL_W'(new_val);
        old_mag = old_reg[VAL_W-1] ? VAL_W'(-old_reg) : VAL_W'(old_reg);
    end

    assign z_last = size_z_reg - 2'd2;
    assign y_last = size_y_reg - 2'd2;
    assign x_last = size_x_reg - 2'd2;
    assign last_cell = mode_reg ? ((xi_reg == x_last) && (yj_reg == y_last) && (zk_reg == z_last))
                                : (c_reg == n_w - 1'b1);

    assign conv_lim  = (SUM_W+1)'(conv_hi_reg) + (SUM_W+1)'(conv_lo_reg[2*TOL_W-1:TOL_W]);
    assign converged = ((SUM_W+1)'(diff_reg) <= conv_lim);

    // ---------------- memory port control ----------------
    always_comb begin
        sol_re    = 1'b0;
        sol_raddr = nb_addr_reg[slot_reg];
        sol_we    = 1'b0;
        sol_waddr = in_addr;
        sol_wdata = s_initial_value;
        if (state_reg == S_FETCH) begin
            sol_re = 1'b1;
        end
        if (in_fire && (s_operation == OP_READ)) begin
            sol_re    = 1'b1;
            sol_raddr = in_addr;
        end
        if (load_we) begin
            sol_we = 1'b1;
        end
        if (state_reg == S_WRITE) begin
            sol_we    = 1'b1;
            sol_waddr = c_reg[AW-1:0];
            sol_wdata = new_val;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire && (s_operation == OP_READ)) begin
                    state_next = S_READ;
                end else if (in_fire && (s_operation == OP_SOLVE)) begin
                    state_next = S_SETUP1;
                end
            end
            S_READ:        state_next = S_IDLE;
            S_SETUP1:      state_next = S_SETUP2;
            S_SETUP2:      state_next = S_SWEEP_START;
            S_SWEEP_START: begin
                if (mode_reg) begin
                    state_next = ((size_x_reg >= SIZE_W'(3)) && (size_y_reg >= SIZE_W'(3)) &&
                                  (size_z_reg >= SIZE_W'(3)) && (vol_reg <= VOL_W'(MAX_CELLS)))
                                 ? S_CELL_START : S_SWEEP_END;
                end else begin
                    state_next = (n_reg == '0) ? S_SWEEP_END : S_CELL_START;
                end
            end
            S_CELL_START:  state_next = S_FETCH;
            S_FETCH:       state_next = S_MUL;
            S_MUL:         state_next = S_ACC;
            S_ACC:         state_next = (slot_reg == SLOT_LAST) ? S_DIV_START : S_FETCH;
            S_DIV_START:   state_next = (cen_reg == '0) ? S_BLEND : S_DIV_WAIT;
            S_DIV_WAIT:    state_next = div_done ? S_BLEND : S_DIV_WAIT;
            S_BLEND:       state_next = S_WRITE;
            S_WRITE:       state_next = last_cell ? S_SWEEP_END : S_CELL_START;
            S_SWEEP_END:   state_next = S_CONV;
            S_CONV: begin
                if ((32'(sweep_cnt_reg) >= MIN_SWEEPS) && converged) begin
                    state_next = S_DONE;
                end else if (sweep_cnt_reg >= max_iter_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SWEEP_START;
                end
            end
            S_DONE:        state_next = S_IDLE;
            default:       state_next = S_IDLE;
        endcase
    end

    // control state
    logic [STATUS_W-1:0] solve_st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            sweep_cnt_reg <= '0;
            zdiv_reg      <= 1'b0;
            sum_new_reg   <= '0;
            sum_old_reg   <= '0;
            solve_st_reg  <= ST_OK;
        end else begin
            state_reg <= state_next;
            // output register: drain, then refill
            if (out_fire) begin
                out_valid_reg <= 1'b0;
            end
            if (in_fire && (s_operation != OP_READ) && (s_operation != OP_SOLVE)) begin
                out_valid_reg <= 1'b1;
            end
            if ((state_reg == S_READ) || (state_reg == S_DONE)) begin
                out_valid_reg <= 1'b1;
            end
            if (in_fire && (s_operation == OP_SOLVE)) begin
                sweep_cnt_reg <= '0;
                zdiv_reg      <= 1'b0;
            end
            if ((state_reg == S_DIV_START) && (cen_reg == '0)) begin
                zdiv_reg <= 1'b1;
            end
            if (state_reg == S_SWEEP_START) begin
                sum_new_reg <= '0;
                sum_old_reg <= '0;
            end
            if (state_reg == S_WRITE) begin
                sum_new_reg <= sum_new_reg + SUM_W'(new_mag);
                sum_old_reg <= sum_old_reg + SUM_W'(old_mag);
            end
            if (state_reg == S_SWEEP_END) begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            end
            if (state_reg == S_CONV) begin
                solve_st_reg <= ((32'(sweep_cnt_reg) >= MIN_SWEEPS) && converged)
                                ? ST_OK : ST_CAP;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        // result beat
        if (in_fire) begin
            out_value_reg  <= '0;
            out_count_reg  <= sweep_cnt_reg;
            out_status_reg <= ST_OK;
        end
        if (state_reg == S_READ) begin
            out_value_reg <= in_range_reg ? sol_rdata : '0;
        end
        if (state_reg == S_DONE) begin
            out_value_reg  <= '0;
            out_count_reg  <= sweep_cnt_reg;
            out_status_reg <= zdiv_reg ? ST_ZERO : solve_st_reg;
        end

        // solve setup
        if (state_reg == S_SETUP1) begin
            sxy_reg <= IDX_W'(size_x_reg) * IDX_W'(size_y_reg);
            n_reg   <= (32'(total_reg) > MAX_CELLS) ? CW'(MAX_CELLS) : CW'(total_reg);
        end
        if (state_reg == S_SETUP2) begin
            vol_reg   <= VOL_W'(sxy_reg) * VOL_W'(size_z_reg);
            zwrap_reg <= sxy_reg * IDX_W'(size_z_reg - 2'd3);
            ywrap_reg <= nx_w * IDX_W'(size_y_reg - 2'd3);
            xwrap_reg <= IDX_W'(size_x_reg - 2'd3);
        end

        // cell walk
        if (state_reg == S_SWEEP_START) begin
            xi_reg  <= SIZE_W'(1);
            yj_reg  <= SIZE_W'(1);
            zk_reg  <= SIZE_W'(1);
            cij_reg <= nx_w + 1'b1;
            c_reg   <= mode_reg ? sxy_reg + nx_w + 1'b1 : '0;
        end
        if ((state_reg == S_WRITE) && !last_cell) begin
            if (!mode_reg) begin
                c_reg <= c_reg + 1'b1;
            end else if (zk_reg != z_last) begin
                zk_reg <= zk_reg + 1'b1;
                c_reg  <= c_reg + sxy_reg;
            end else if (yj_reg != y_last) begin
                zk_reg  <= SIZE_W'(1);
                yj_reg  <= yj_reg + 1'b1;
                cij_reg <= cij_reg + nx_w;
                c_reg   <= sxy_reg + cij_reg + nx_w;
            end else begin
                zk_reg  <= SIZE_W'(1);
                yj_reg  <= SIZE_W'(1);
                xi_reg  <= xi_reg + 1'b1;
                cij_reg <= nx_w + IDX_W'(xi_reg) + 1'b1;
                c_reg   <= sxy_reg + nx_w + IDX_W'(xi_reg) + 1'b1;
            end
        end

        // latch neighbor list, restart slot walk
        if (state_reg == S_CELL_START) begin
            for (int s = 0; s < SLOTS; s++) begin
                nb_addr_reg[s] <= nb_idx[s][AW-1:0];
            end
            nb_pres_reg <= nb_pres;
            slot_reg    <= '0;
        end

        // multiply coefficient by neighbor value
        if (state_reg == S_MUL) begin
            prod_reg <= (2*VAL_W)'(coef_slot) * (2*VAL_W)'($signed(sol_rdata));
            if (slot_reg == SLOT_CENTER) begin
                old_reg <= sol_rdata;
                cen_reg <= coef_slot;
            end
            if (slot_reg == '0) begin
                acc_reg <= ACC_W'($signed(rhs_rdata));
            end
        end

        // subtract floored product
        if (state_reg == S_ACC) begin
            if (nb_pres_reg[slot_reg]) begin
                acc_reg <= acc_reg - ACC_W'(prod_reg >>> 16);
            end
            slot_reg <= slot_reg + 1'b1;
        end

        if (state_reg == S_DIV_START) begin
            neg_reg <= r_sat[ACC_W-1] ^ cen_reg[VAL_W-1];
            t_reg   <= r_sat[ACC_W-1] ? VAL_MIN : VAL_MAX;
        end
        if ((state_reg == S_DIV_WAIT) && div_done) begin
            t_reg <= t_div;
        end

        if (state_reg == S_BLEND) begin
            blend_reg <= (VAL_W+RELAX_W+3)'($signed({2'b00, relax_reg}))
                         * (VAL_W+RELAX_W+3)'(diff_t);
        end

        // convergence products
        if (state_reg == S_SWEEP_END) begin
            diff_reg    <= (sum_new_reg > sum_old_reg) ? sum_new_reg - sum_old_reg
                                                       : sum_old_reg - sum_new_reg;
            conv_hi_reg <= SUM_W'(tol_reg) * SUM_W'(sum_new_reg[SUM_W-1:32]);
            conv_lo_reg <= (2*TOL_W)'(tol_reg) * (2*TOL_W)'(sum_new_reg[31:0]);
        end
    end

    // remember whether the read address was in range
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_range_reg <= in_range;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_cell_value      = out_value_reg;
    assign m_iteration_count = out_count_reg;
    assign m_status          = out_status_reg;

    // ---------------- assertions ----------------
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (cen_reg != '0))
        else $error("divider started with zero center coefficient");

    a_solve_enters_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (s_operation == OP_SOLVE)) |=> (state_reg == S_SETUP1))
        else $error("solve beat did not start setup");

    a_done_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |=> (out_valid_reg && (out_count_reg == $past(sweep_cnt_reg))))
        else $error("solve result not presented");

    a_cap_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_status_reg == ST_CAP)) |-> (out_count_reg >= max_iter_reg))
        else $error("cap status with count below the cap");

endmodule

// ----- tb/sv/sor_solve_checker.sv -----
// Result checker for the seven-point stencil solver: watches the register port and
// both beat channels, predicts every result beat and compares it field by field.
// Depends on sor_pkg.
module sor_solve_checker
    import sor_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [OP_W-1:0]             s_operation,
    input  logic [CIDX_W-1:0]           s_cell_index,
    input  logic signed [VAL_W-1:0]     s_coeff_back_z,
    input  logic signed [VAL_W-1:0]     s_coeff_back_y,
    input  logic signed [VAL_W-1:0]     s_coeff_back_x,
    input  logic signed [VAL_W-1:0]     s_coeff_center,
    input  logic signed [VAL_W-1:0]     s_coeff_front_x,
    input  logic signed [VAL_W-1:0]     s_coeff_front_y,
    input  logic signed [VAL_W-1:0]     s_coeff_front_z,
    input  logic signed [VAL_W-1:0]     s_rhs_value,
    input  logic signed [VAL_W-1:0]     s_initial_value,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic signed [VAL_W-1:0]     m_cell_value,
    input  logic [ITER_W-1:0]           m_iteration_count,
    input  logic [STATUS_W-1:0]         m_status,
    output int                          fail_count,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint RESID_MAX = 64'sd140737488355327;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic [ITER_W-1:0]       sweeps;
        status_t                 status;
    } solver_beat_t;

    solver_beat_t result_queue[$];

    // Mirrored cell memories and registers
    logic signed [VAL_W-1:0] coef_mem [SOR_MAX_CELLS][SLOTS];
    logic signed [VAL_W-1:0] rhs_mem  [SOR_MAX_CELLS];
    logic signed [VAL_W-1:0] sol_mem  [SOR_MAX_CELLS];
    logic                    mode_r;
    logic [SIZE_W-1:0]       nx_r, ny_r, nz_r, ncells_r;
    logic [TOL_W-1:0]        tol_r;
    logic [RELAX_W-1:0]      w_r;
    logic [ITER_W-1:0]       cap_r;
    logic [ITER_W-1:0]       sweeps_r;
    logic [63:0]             sum_new, sum_old;
    bit                      zero_div;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Relax one cell against its present neighbors
    function automatic void relax_cell(longint c, longint nb[SLOTS]);
        longint r, t, cen, old, nv;
        r = rhs_mem[c];
        for (int k = 0; k < SLOTS; k++) begin
            if (k == SLOT_CENTER || nb[k] < 0 || nb[k] >= SOR_MAX_CELLS) continue;
            r -= (longint'(coef_mem[c][k]) * longint'(sol_mem[nb[k]])) >>> 16;
        end
        if (r > RESID_MAX) r = RESID_MAX;
        if (r < -RESID_MAX) r = -RESID_MAX;
        cen = coef_mem[c][SLOT_CENTER];
        if (cen == 0) begin
            zero_div = 1;
            t = (r >= 0) ? 64'sd2147483647 : -64'sd2147483648;
        end else begin
            t = clamp32((r * 65536) / cen);
        end
        old = sol_mem[c];
        nv = clamp32(old + ((longint'(w_r) * (t - old)) >>> 14));
        sol_mem[c] = nv[VAL_W-1:0];
        sum_new += 64'(nv < 0 ? -nv : nv);
        sum_old += 64'(old < 0 ? -old : old);
    endfunction

    function automatic void sweep_banded();
        longint n, nx, sxy;
        longint nb[SLOTS];
        n = (ncells_r > SOR_MAX_CELLS) ? SOR_MAX_CELLS : ncells_r;
        nx = nx_r;
        sxy = longint'(nx_r) * longint'(ny_r);
        for (longint i = 0; i < n; i++) begin
            nb[0] = (i >= sxy) ? i - sxy : -1;
            nb[1] = (i >= nx) ? i - nx : -1;
            nb[2] = (i >= 1) ? i - 1 : -1;
            nb[3] = -1;
            nb[4] = (i + 1 < n) ? i + 1 : -1;
            nb[5] = (i + nx < n) ? i + nx : -1;
            nb[6] = (i + sxy < n) ? i + sxy : -1;
            relax_cell(i, nb);
        end
    endfunction

    // Interior sweep, x outermost, wrapping between 1 and size-2
    function automatic void sweep_periodic();
        longint nx, ny, nz, sxy, ib, ifw, jb, jf, kb, kf;
        longint nb[SLOTS];
        nx = nx_r;
        ny = ny_r;
        nz = nz_r;
        sxy = nx * ny;
        if (nx < 3 || ny < 3 || nz < 3 || sxy * nz > SOR_MAX_CELLS) return;
        for (longint i = 1; i + 1 < nx; i++)
            for (longint j = 1; j + 1 < ny; j++)
                for (longint k = 1; k + 1 < nz; k++) begin
                    ib = (i == 1) ? nx - 2 : i - 1;
                    ifw = (i == nx - 2) ? 1 : i + 1;
                    jb = (j == 1) ? ny - 2 : j - 1;
                    jf = (j == ny - 2) ? 1 : j + 1;
                    kb = (k == 1) ? nz - 2 : k - 1;
                    kf = (k == nz - 2) ? 1 : k + 1;
                    nb[0] = kb * sxy + j * nx + i;
                    nb[1] = k * sxy + jb * nx + i;
                    nb[2] = k * sxy + j * nx + ib;
                    nb[3] = -1;
                    nb[4] = k * sxy + j * nx + ifw;
                    nb[5] = k * sxy + jf * nx + i;
                    nb[6] = kf * sxy + j * nx + i;
                    relax_cell(k * sxy + j * nx + i, nb);
                end
    endfunction

    function automatic bit sums_converged();
        logic [63:0] d, lim;
        d = (sum_new > sum_old) ? sum_new - sum_old : sum_old - sum_new;
        lim = 64'(tol_r) * (sum_new >> 32) + ((64'(tol_r) * 64'(sum_new[31:0])) >> 32);
        return d <= lim;
    endfunction

    function automatic status_t run_solve();
        int m;
        status_t st;
        m = 0;
        zero_div = 0;
        while (1) begin
            sum_new = '0;
            sum_old = '0;
            if (mode_r) sweep_periodic();
            else sweep_banded();
            m++;
            if (m >= SOR_MIN_SWEEPS && sums_converged()) begin
                st = ST_OK;
                break;
            end
            if (m >= cap_r) begin
                st = ST_CAP;
                break;
            end
        end
        sweeps_r = m[ITER_W-1:0];
        return zero_div ? ST_ZERO : st;
    endfunction

    // Predict on accepted commands, compare on accepted results
    always @(posedge aclk) begin
        solver_beat_t want;
        int c;
        if (!aresetn) begin
            mode_r   = 1'b0;
            nx_r     = 13'd16;
            ny_r     = 13'd16;
            nz_r     = 13'd16;
            ncells_r = 13'd4096;
            tol_r    = 32'd4295;
            w_r      = 15'd31130;
            cap_r    = 16'd1000;
            sweeps_r = '0;
            sum_new  = '0;
            sum_old  = '0;
            result_queue.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MODE:   mode_r = cfg_wdata[0];
                    CFG_SIZE_X: nx_r = cfg_wdata[SIZE_W-1:0];
                    CFG_SIZE_Y: ny_r = cfg_wdata[SIZE_W-1:0];
                    CFG_SIZE_Z: nz_r = cfg_wdata[SIZE_W-1:0];
                    CFG_TOTAL:  ncells_r = cfg_wdata[SIZE_W-1:0];
                    CFG_TOL:    tol_r = cfg_wdata[TOL_W-1:0];
                    CFG_RELAX:  w_r = cfg_wdata[RELAX_W-1:0];
                    CFG_MAXIT:  cap_r = cfg_wdata[ITER_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                c = s_cell_index;
                want.value = '0;
                want.status = ST_OK;
                case (op_t'(s_operation))
                    OP_LOAD: begin
                        coef_mem[c][0] = s_coeff_back_z;
                        coef_mem[c][1] = s_coeff_back_y;
                        coef_mem[c][2] = s_coeff_back_x;
                        coef_mem[c][3] = s_coeff_center;
                        coef_mem[c][4] = s_coeff_front_x;
                        coef_mem[c][5] = s_coeff_front_y;
                        coef_mem[c][6] = s_coeff_front_z;
                        rhs_mem[c] = s_rhs_value;
                        sol_mem[c] = s_initial_value;
                    end
                    OP_SOLVE: want.status = run_solve();
                    OP_READ:  want.value = sol_mem[c];
                    default: ;
                endcase
                want.sweeps = sweeps_r;
                result_queue.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (result_queue.size() == 0) begin
                    $display("%0t: unexpected result beat value %0d sweeps %0d status %0d",
                             $time, m_cell_value, m_iteration_count, m_status);
                    fail_count++;
                end else begin
                    want = result_queue.pop_front();
                    if (m_cell_value !== want.value) begin
                        $display("%0t: cell_value expected %0d actual %0d",
                                 $time, want.value, m_cell_value);
                        fail_count++;
                    end
                    if (m_iteration_count !== want.sweeps) begin
                        $display("%0t: iteration_count expected %0d actual %0d",
                                 $time, want.sweeps, m_iteration_count);
                        fail_count++;
                    end
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                        fail_count++;
                    end
                end
            end
        end
        pending = result_queue.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
    end

    // Report results still owed when the run ends
    function automatic int leftover();
        return result_queue.size();
    endfunction

endmodule

// ----- tb/sv/tb_sor_stencil7_solver.sv -----
// Top testbench for sor_stencil7_solver: clock, reset, register writes, command
// stimulus and result back-pressure; the checker does prediction and comparison.
// Depends on sor_pkg, sor_stencil7_solver and sor_solve_checker.
module tb_sor_stencil7_solver;
    import sor_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 12;
    localparam int PHASE_BEATS = 75;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    s_valid, s_ready;
    logic [OP_W-1:0]         s_operation;
    logic [CIDX_W-1:0]       s_cell_index;
    logic signed [VAL_W-1:0] s_cf [SLOTS];
    logic signed [VAL_W-1:0] s_rhs_value, s_initial_value;
    logic                    m_valid, m_ready;
    logic signed [VAL_W-1:0] m_cell_value;
    logic [ITER_W-1:0]       m_iteration_count;
    logic [STATUS_W-1:0]     m_status;
    int                      fail_count, pending;

    bit tx_gaps, rx_gaps, hold_req;
    bit loaded [SOR_MAX_CELLS];
    int loaded_list[$];
    int active_cells;

    sor_stencil7_solver u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_cell_index(s_cell_index),
        .s_coeff_back_z(s_cf[0]), .s_coeff_back_y(s_cf[1]), .s_coeff_back_x(s_cf[2]),
        .s_coeff_center(s_cf[3]), .s_coeff_front_x(s_cf[4]), .s_coeff_front_y(s_cf[5]),
        .s_coeff_front_z(s_cf[6]), .s_rhs_value(s_rhs_value),
        .s_initial_value(s_initial_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_cell_value(m_cell_value),
        .m_iteration_count(m_iteration_count), .m_status(m_status)
    );

    sor_solve_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_cell_index(s_cell_index),
        .s_coeff_back_z(s_cf[0]), .s_coeff_back_y(s_cf[1]), .s_coeff_back_x(s_cf[2]),
        .s_coeff_center(s_cf[3]), .s_coeff_front_x(s_cf[4]), .s_coeff_front_y(s_cf[5]),
        .s_coeff_front_z(s_cf[6]), .s_rhs_value(s_rhs_value),
        .s_initial_value(s_initial_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_cell_value(m_cell_value),
        .m_iteration_count(m_iteration_count), .m_status(m_status),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one beat and hold it until accepted; call at a rising edge
    task automatic send(op_t op, int idx, int cf[SLOTS], int rhs, int init);
        int g;
        s_valid <= 1'b1;
        s_operation <= op;
        s_cell_index <= idx[CIDX_W-1:0];
        for (int k = 0; k < SLOTS; k++) s_cf[k] <= cf[k];
        s_rhs_value <= rhs;
        s_initial_value <= init;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        g = tx_gaps ? pick_gap() : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic send_cmd(op_t op, int idx);
        int cf[SLOTS];
        foreach (cf[k]) cf[k] = $urandom;
        send(op, idx, cf, $urandom, $urandom);
    endtask

    // Center-heavy cell with small neighbor coefficients when sane, raw bits otherwise
    task automatic load_cell(int idx, bit sane);
        int cf[SLOTS];
        int rhs, init;
        if (sane) begin
            foreach (cf[k]) cf[k] = int'($urandom_range(0, 65536)) - 32768;
            cf[SLOT_CENTER] = $urandom_range(2 << 16, 8 << 16);
            if ($urandom_range(0, 3) == 0) cf[SLOT_CENTER] = -cf[SLOT_CENTER];
            rhs = int'($urandom_range(0, 2 << 20)) - (1 << 20);
            init = int'($urandom_range(0, 2 << 18)) - (1 << 18);
        end else begin
            foreach (cf[k]) cf[k] = $urandom;
            rhs = $urandom;
            init = $urandom;
        end
        send(OP_LOAD, idx, cf, rhs, init);
        if (!loaded[idx]) begin
            loaded[idx] = 1;
            loaded_list.push_back(idx);
        end
    endtask

    // Drop valid and wait until every result is back
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_regs(int mode, int sx, int sy, int sz, int total,
                              logic [31:0] tol, int w, int cap);
        logic [31:0] vals [8];
        vals = '{mode, sx, sy, sz, total, tol, w, cap};
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (mode == 0) active_cells = (total > SOR_MAX_CELLS) ? SOR_MAX_CELLS : total;
        else if (sx < 3 || sy < 3 || sz < 3 || sx * sy * sz > SOR_MAX_CELLS) active_cells = 0;
        else active_cells = sx * sy * sz;
    endtask

    // Every cell a solve touches must hold data first
    task automatic solve_ready();
        for (int i = 0; i < active_cells; i++)
            if (!loaded[i]) load_cell(i, 1);
        send_cmd(OP_SOLVE, 0);
    endtask

    // Result side back-pressure
    initial begin
        int g;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 0;
                m_ready <= 1'b1;
            end else begin
                g = rx_gaps ? pick_gap() : 0;
                if (g > 0) begin
                    m_ready <= 1'b0;
                    repeat (g) @(posedge aclk);
                end
                m_ready <= 1'b1;
            end
        end
    end

    // Give up when nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("sor_stencil7_solver regression: fail");
                $finish;
            end
        end
    end

    initial begin
        int cf[SLOTS];
        int r, idx, mode;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_operation = '0;
        s_cell_index = '0;
        foreach (s_cf[k]) s_cf[k] = '0;
        s_rhs_value = '0;
        s_initial_value = '0;
        tx_gaps = 1;
        rx_gaps = 1;
        hold_req = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, every operation, zero divisor
        write_regs(0, 3, 3, 3, 8, 32'd4295, 16384, 6);
        for (int i = 0; i < 8; i++) load_cell(i, 1);
        foreach (cf[k]) cf[k] = 32'h7FFFFFFF;
        send(OP_LOAD, 4095, cf, 32'h80000000, 32'hFFFFFFFF);
        foreach (cf[k]) cf[k] = 32'h80000000;
        send(OP_LOAD, 4094, cf, 32'h7FFFFFFF, 32'h00000000);
        loaded[4095] = 1;
        loaded[4094] = 1;
        loaded_list.push_back(4095);
        loaded_list.push_back(4094);
        send_cmd(OP_READ, 4095);
        send_cmd(OP_READ, 4094);
        send_cmd(OP_UNUSED, 0);
        send_cmd(OP_SOLVE, 0);
        send_cmd(OP_READ, 0);
        send_cmd(OP_READ, 7);
        foreach (cf[k]) cf[k] = 32'h00001000;
        cf[SLOT_CENTER] = 0;
        send(OP_LOAD, 3, cf, 32'h00030000, 32'h00010000);
        send_cmd(OP_SOLVE, 0);
        send_cmd(OP_READ, 3);
        load_cell(3, 1);
        send_cmd(OP_UNUSED, 4095);

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            drain();
            tx_gaps = (p % 4) != 2;
            rx_gaps = (p % 5) != 3;
            if (p == 0)
                write_regs(1, 4096, 4096, 4096, 4096, 32'hFFFFFFFF, 32767, 65535);
            else if (p == 1)
                write_regs(0, 3, 3, 3, 1, 32'd0, 0, 5);
            else if (p == 2)
                write_regs(0, 4096, 4096, 3, $urandom_range(2, 12), $urandom, 16384, 6);
            else begin
                mode = $urandom_range(0, 1);
                write_regs(mode, $urandom_range(3, 5), $urandom_range(3, 5),
                           $urandom_range(3, 5), $urandom_range(2, 12),
                           ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 65535)),
                           $urandom_range(8192, 24576), $urandom_range(5, 8));
            end
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (p == 3 && n == 10) hold_req = 1;
                r = $urandom_range(0, 99);
                if (r < 3) solve_ready();
                else if (r < 5) send_cmd(OP_UNUSED, $urandom_range(0, 4095));
                else if (r < 35) begin
                    idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                    send_cmd(OP_READ, idx);
                end else begin
                    if ($urandom_range(0, 4) != 0)
                        idx = $urandom_range(0, (active_cells > 8 ? active_cells : 8) - 1);
                    else
                        idx = $urandom_range(0, 4095);
                    load_cell(idx, $urandom_range(0, 99) < 85);
                end
            end
            solve_ready();
            idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            send_cmd(OP_READ, idx);
        end

        drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("sor_stencil7_solver regression: pass");
        else
            $display("sor_stencil7_solver regression: fail");
        $finish;
    end

endmodule
